### rtl/core/assert_macros.svh
// Assertion macros for the RTL in this folder.
// No dependencies; the bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_RST(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_CLK(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(lbl, clk, rst, prop, msg)
`define ASSERT_CLK(lbl, clk, prop, msg)
`endif
`endif

### rtl/core/rmgr_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the running minimum gap and range block.
// No dependencies.
package rmgr_pkg;

  localparam int VALUE_W          = 32;
  localparam int COUNT_W          = 11;
  localparam int DEF_MAX_CAPACITY = 1024;
  localparam int OUT_TDATA_W      = 80;

  localparam logic [COUNT_W-1:0] CAPACITY_RESET = 11'd1024;

  localparam logic STATUS_STORED = 1'b0;
  localparam logic STATUS_FULL   = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH,
    ST_EMIT
  } state_t;

endpackage

### rtl/core/running_min_gap_and_range.sv
`timescale 1ns / 1ps
// Top level: set of signed values with running minimum gap and range.
// Depends on rmgr_pkg, rmgr_store and assert_macros.svh.
//
//  channel | direction | ports                                | content
//  --------+-----------+--------------------------------------+---------------------------
//  s_      | in        | s_tvalid s_tready s_tdata s_tuser    | value, clear_first
//  m_      | out       | m_tvalid m_tready m_tdata m_tuser    | counts, spans, status
//  cfg_    | in        | cfg_we cfg_wdata                     | capacity register
//
// An insert into a set of n >= 1 values reads every stored value once through the one RAM
// port before the next transaction is taken; an insert into an empty set skips this scan,
// and a value dropped because the set is full goes from the check straight to the result.
// Reset empties the set and sets capacity to 1024; the RAM itself is not cleared.
// A new transaction is taken while an earlier result still waits on m_; the
// block holds in its last state only if that result has not yet been taken.
`include "assert_macros.svh"

module running_min_gap_and_range #(
  parameter int MAX_CAPACITY = rmgr_pkg::DEF_MAX_CAPACITY
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [31:0]                         s_tdata,  // [31:0] value
  input  logic                                s_tuser,  // [0] clear_first
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [10:0] count, [11] span_valid, [43:12] closest_gap, [75:44] longest_span,
  // [79:76] zero
  output logic [rmgr_pkg::OUT_TDATA_W-1:0]    m_tdata,
  output logic                                m_tuser,  // [0] status
  input  logic                                cfg_we,
  input  logic [rmgr_pkg::COUNT_W-1:0]        cfg_wdata
);

  localparam int AW = $clog2(MAX_CAPACITY);
  localparam int CW = rmgr_pkg::COUNT_W;
  localparam int VW = rmgr_pkg::VALUE_W;

  rmgr_pkg::state_t state, state_next;

  logic [CW-1:0]        capacity;
  logic [CW-1:0]        held;
  logic [CW-1:0]        idx;
  logic [VW-1:0]        min_gap;
  logic signed [VW-1:0] min_value;
  logic signed [VW-1:0] max_value;
  logic signed [VW-1:0] val;
  logic                 status;

  logic                 rd_pending;
  logic                 gap_valid;
  logic [VW-1:0]        gap_cand;
  logic [VW-1:0]        rd_data;

  logic                 mem_we;
  logic                 full;
  logic                 out_load;
  logic signed [VW:0]   diff_vr;
  logic [VW-1:0]        diff_rv;

  logic [CW-1:0]        out_count;
  logic                 out_span_valid;
  logic [VW-1:0]        out_short;
  logic [VW-1:0]        out_long;

  rmgr_store #(
    .DEPTH (MAX_CAPACITY),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (AW'(held)),
    .wdata (val),
    .raddr (AW'(idx)),
    .rdata (rd_data)
  );

  assign s_tready = (state == rmgr_pkg::ST_IDLE);
  assign full     = (held >= capacity) || (32'(held) >= MAX_CAPACITY);
  assign mem_we   = (state == rmgr_pkg::ST_FINISH);
  assign out_load = (state == rmgr_pkg::ST_EMIT) && (!m_tvalid || m_tready);

  // The 33-bit difference gives the sign; when it is negative the reverse
  // difference, which always fits in 32 bits, is the gap.
  assign diff_vr = {val[VW-1], val} - {rd_data[VW-1], rd_data};
  assign diff_rv = rd_data - val;

  always_comb begin
    state_next = state;
    unique case (state)
      rmgr_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          state_next = rmgr_pkg::ST_CHECK;
        end
      end
      rmgr_pkg::ST_CHECK: begin
        if (full) begin
          state_next = rmgr_pkg::ST_EMIT;
        end else if (held == '0) begin
          state_next = rmgr_pkg::ST_FINISH;
        end else begin
          state_next = rmgr_pkg::ST_SCAN;
        end
      end
      rmgr_pkg::ST_SCAN: begin
        if (idx == held - CW'(1)) begin
          state_next = rmgr_pkg::ST_DRAIN;
        end
      end
      rmgr_pkg::ST_DRAIN: begin
        if (!rd_pending && !gap_valid) begin
          state_next = rmgr_pkg::ST_FINISH;
        end
      end
      rmgr_pkg::ST_FINISH: begin
        state_next = rmgr_pkg::ST_EMIT;
      end
      rmgr_pkg::ST_EMIT: begin
        if (!m_tvalid || m_tready) begin
          state_next = rmgr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = rmgr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rmgr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= rmgr_pkg::CAPACITY_RESET;
    end else if (cfg_we) begin
      capacity <= cfg_wdata;
    end
  end

  // Set state, running statistics and scan pipeline flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      held       <= '0;
      min_gap    <= '1;
      min_value  <= '0;
      max_value  <= '0;
      rd_pending <= 1'b0;
      gap_valid  <= 1'b0;
    end else begin
      rd_pending <= (state == rmgr_pkg::ST_SCAN);
      gap_valid  <= rd_pending;
      if (gap_valid && (gap_cand < min_gap)) begin
        min_gap <= gap_cand;
      end
      unique case (state)
        rmgr_pkg::ST_IDLE: begin
          if (s_tvalid && s_tuser) begin
            held      <= '0;
            min_gap   <= '1;
            min_value <= '0;
            max_value <= '0;
          end
        end
        rmgr_pkg::ST_FINISH: begin
          held <= held + CW'(1);
          if (held == '0) begin
            min_value <= val;
            max_value <= val;
          end else begin
            if (val < min_value) begin
              min_value <= val;
            end
            if (val > max_value) begin
              max_value <= val;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Payload, scan pointer, status and gap candidate.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      val <= s_tdata;
    end
    if (state == rmgr_pkg::ST_CHECK) begin
      idx    <= '0;
      status <= full ? rmgr_pkg::STATUS_FULL : rmgr_pkg::STATUS_STORED;
    end else if (state == rmgr_pkg::ST_SCAN) begin
      idx <= idx + CW'(1);
    end
    gap_cand <= diff_vr[VW] ? diff_rv : diff_vr[VW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_count      <= held;
      out_span_valid <= (held >= CW'(2));
      out_short      <= (held >= CW'(2)) ? min_gap : '0;
      out_long       <= (held >= CW'(2)) ? (max_value - min_value) : '0;
      m_tuser        <= status;
    end
  end

  assign m_tdata = {4'b0000, out_long, out_short, out_span_valid, out_count};

  `ASSERT_RST(a_accept_drops_ready, clk, rst, (s_tvalid && s_tready) |=> !s_tready,
              "ready stayed high after a transaction")
  `ASSERT_RST(a_scan_in_range, clk, rst, (state == rmgr_pkg::ST_SCAN) |-> (idx < held),
              "scan index beyond the held values")
  `ASSERT_RST(a_gap_monotonic, clk, rst, gap_valid |=> (min_gap <= $past(min_gap)),
              "minimum gap grew during a scan")
  `ASSERT_RST(a_write_in_range, clk, rst,
              mem_we |-> ((32'(held) < MAX_CAPACITY) && (held < capacity)),
              "store written beyond capacity")
  `ASSERT_CLK(a_reset_idle, clk, $past(rst) |-> (state == rmgr_pkg::ST_IDLE) && !m_tvalid,
              "block not idle after reset")

endmodule

### rtl/core/rmgr_store.sv
`timescale 1ns / 1ps
// Value store: single-port-write, single-port-read synchronous RAM.
// Depends on rmgr_pkg for the value width and the default depth.
module rmgr_store #(
  parameter int DEPTH = rmgr_pkg::DEF_MAX_CAPACITY,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [AW-1:0]                    waddr,
  input  logic [rmgr_pkg::VALUE_W-1:0]     wdata,
  input  logic [AW-1:0]                    raddr,
  output logic [rmgr_pkg::VALUE_W-1:0]     rdata
);

  logic [rmgr_pkg::VALUE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
